[sv/lcs_pkg.sv]
// Shared constants, types and the sequencer state encoding for the LCS length core.
`timescale 1ns / 1ps
`default_nettype none

package lcs_pkg;

    // Store depth and derived widths.
    localparam int MAX_LEN = 64;
    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int SYM_W   = 8;
    localparam int SCORE_W = 7;

    // Input operation codes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_FEED = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_EMIT
    } t_state;

    // Control from the sequencer to the score update unit.
    typedef struct packed {
        logic start;
        logic step;
    } t_pe_ctrl;

endpackage

`default_nettype wire

[sv/lcs_store.sv]
// Memory that holds the symbols of the first string.
`timescale 1ns / 1ps
`default_nettype none

module lcs_store (
    input  wire                         i_clk,
    input  wire                         i_wr_en,
    input  wire [lcs_pkg::ADDR_W-1:0]   i_wr_addr,
    input  wire [lcs_pkg::SYM_W-1:0]    i_wr_data,
    input  wire                         i_rd_en,
    input  wire [lcs_pkg::ADDR_W-1:0]   i_rd_addr,
    output logic [lcs_pkg::SYM_W-1:0]   o_rd_data
);
    import lcs_pkg::*;

    logic [SYM_W-1:0] r_mem [MAX_LEN];
    logic [SYM_W-1:0] r_rd_data;

    // Single write port, registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[sv/lcs_row.sv]
// Score row memory with per-entry valid bits so a single clear empties the whole row.
`timescale 1ns / 1ps
`default_nettype none

module lcs_row (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_clear,
    input  wire                         i_wr_en,
    input  wire [lcs_pkg::ADDR_W-1:0]   i_wr_addr,
    input  wire [lcs_pkg::SCORE_W-1:0]  i_wr_data,
    input  wire                         i_rd_en,
    input  wire [lcs_pkg::ADDR_W-1:0]   i_rd_addr,
    output logic [lcs_pkg::SCORE_W-1:0] o_rd_data
);
    import lcs_pkg::*;

    logic [SCORE_W-1:0] r_mem [MAX_LEN];
    logic [SCORE_W-1:0] r_rd_data;
    logic [MAX_LEN-1:0] r_valid;
    logic [MAX_LEN-1:0] n_valid;
    logic               r_rd_valid;

    // Valid bits: a clear drops them all, a write marks its entry.
    always_comb begin
        n_valid = r_valid;
        if (i_clear) begin
            n_valid = '0;
        end else if (i_wr_en) begin
            n_valid[i_wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Data array with a registered read; the valid bit is sampled alongside.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    // An entry never written since the last clear reads as zero.
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

[sv/lcs_pe.sv]
// Shared score update unit: compare, increment and max for one row position per cycle.
`timescale 1ns / 1ps
`default_nettype none

module lcs_pe (
    input  wire                          i_clk,
    input  wire lcs_pkg::t_pe_ctrl       i_ctrl,
    input  wire  [lcs_pkg::SYM_W-1:0]    i_sym,
    input  wire  [lcs_pkg::SYM_W-1:0]    i_stored_sym,
    input  wire  [lcs_pkg::SCORE_W-1:0]  i_old,
    output logic [lcs_pkg::SCORE_W-1:0]  o_fresh,
    output logic [lcs_pkg::SCORE_W-1:0]  o_below
);
    import lcs_pkg::*;

    logic [SCORE_W-1:0] r_diag;
    logic [SCORE_W-1:0] r_below;

    // Match takes the diagonal plus one (wrapping at the score width),
    // otherwise the larger of the new lower neighbor and the old value.
    always_comb begin
        if (i_stored_sym == i_sym) begin
            o_fresh = r_diag + SCORE_W'(1);
        end else if (r_below > i_old) begin
            o_fresh = r_below;
        end else begin
            o_fresh = i_old;
        end
    end

    // Carry the diagonal and lower neighbor along the row.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_diag  <= '0;
            r_below <= '0;
        end else if (i_ctrl.step) begin
            r_diag  <= i_old;
            r_below <= o_fresh;
        end
    end

    assign o_below = r_below;

endmodule

`default_nettype wire

[sv/lcs_length_core.sv]
// Top level of the LCS length core: input handling, row sequencer and result register.
// A first-string beat leaves o_stall low. After a second-string beat o_stall stays high while
// S_RUN walks the stored first-string symbols, if any: one row position per cycle
// through the shared update unit, one read per cycle from each memory.
// A beat with last set then passes S_EMIT, which waits for any held result, and its result
// goes to the result register. Reset is synchronous, active low; it empties the score row.
`timescale 1ns / 1ps
`default_nettype none

module lcs_length_core (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire                          i_operation,
    input  wire  [lcs_pkg::SYM_W-1:0]    i_symbol,
    input  wire                          i_last,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [lcs_pkg::SCORE_W-1:0]  o_length,
    output logic                         o_overflow
);
    import lcs_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [LEN_W-1:0]   r_first_len;
    logic               r_trunc;
    logic               r_restart;
    logic [LEN_W-1:0]   r_idx;
    logic [LEN_W-1:0]   r_n;
    logic [SYM_W-1:0]   r_sym;
    logic               r_last;
    logic               r_out_valid;
    logic [SCORE_W-1:0] r_out_length;
    logic               r_out_overflow;

    logic               w_accept;
    logic               w_load;
    logic               w_feed;
    logic [LEN_W-1:0]   w_len_base;
    logic               w_room;
    logic               w_out_free;
    logic               w_run_done;
    logic [LEN_W-1:0]   w_wr_idx;
    logic               w_rd_en;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic               w_row_wr;
    logic               w_row_clear;
    logic               w_emit;
    t_pe_ctrl           w_pe_ctrl;
    logic [SYM_W-1:0]   w_stored_sym;
    logic [SCORE_W-1:0] w_old;
    logic [SCORE_W-1:0] w_fresh;
    logic [SCORE_W-1:0] w_below;

    // Input beat decode.
    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_load     = w_accept && (i_operation == OP_LOAD);
    assign w_feed     = w_accept && (i_operation == OP_FEED);
    assign w_len_base = r_restart ? '0 : r_first_len;
    assign w_room     = (int'(w_len_base) < MAX_LEN);
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_run_done = (r_idx == r_n);
    assign w_wr_idx   = r_idx - LEN_W'(1);

    // Next state. A query runs over the stored symbols whether or not the
    // first string has been closed by its last mark.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_feed) begin
                    if (r_first_len != '0) begin
                        n_state = S_RUN;
                    end else if (i_last) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_RUN: begin
                if (w_run_done) begin
                    n_state = r_last ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        w_rd_en         = 1'b0;
        w_rd_addr       = '0;
        w_row_wr        = 1'b0;
        w_row_clear     = 1'b0;
        w_emit          = 1'b0;
        w_pe_ctrl.start = 1'b0;
        w_pe_ctrl.step  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_feed) begin
                    w_pe_ctrl.start = 1'b1;
                    w_rd_en         = 1'b1;
                end
                if (w_load && i_last) begin
                    w_row_clear = 1'b1;
                end
            end
            S_RUN: begin
                w_row_wr       = 1'b1;
                w_pe_ctrl.step = 1'b1;
                if (!w_run_done) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_idx[ADDR_W-1:0];
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_emit      = 1'b1;
                    w_row_clear = 1'b1;
                end
            end
            default: begin
                w_rd_en = 1'b0;
            end
        endcase
    end

    // State and first-string bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first_len <= '0;
            r_trunc     <= 1'b0;
            r_restart   <= 1'b1;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_restart <= i_last;
                if (w_room) begin
                    r_first_len <= w_len_base + LEN_W'(1);
                    r_trunc     <= r_restart ? 1'b0 : r_trunc;
                end else begin
                    r_first_len <= w_len_base;
                    r_trunc     <= 1'b1;
                end
            end
        end
    end

    // Row walk counter and the latched second-string beat.
    always_ff @(posedge i_clk) begin
        if (w_feed) begin
            r_idx  <= LEN_W'(1);
            r_n    <= r_first_len;
            r_sym  <= i_symbol;
            r_last <= i_last;
        end else if (r_state == S_RUN && !w_run_done) begin
            r_idx <= r_idx + LEN_W'(1);
        end
    end

    // Output register; it frees as soon as the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_length   <= w_below;
            r_out_overflow <= r_trunc;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_length   = r_out_length;
    assign o_overflow = r_out_overflow;

    // First-string symbol store.
    lcs_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_load && w_room),
        .i_wr_addr (w_len_base[ADDR_W-1:0]),
        .i_wr_data (i_symbol),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_stored_sym)
    );

    // Score row.
    lcs_row u_row (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_row_clear),
        .i_wr_en   (w_row_wr),
        .i_wr_addr (w_wr_idx[ADDR_W-1:0]),
        .i_wr_data (w_fresh),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_old)
    );

    // Shared update unit.
    lcs_pe u_pe (
        .i_clk        (i_clk),
        .i_ctrl       (w_pe_ctrl),
        .i_sym        (r_sym),
        .i_stored_sym (w_stored_sym),
        .i_old        (w_old),
        .o_fresh      (w_fresh),
        .o_below      (w_below)
    );

endmodule

`default_nettype wire

[sv/lcs_checker.sv]
// Port-level checker for the LCS length core and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lcs_checker (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    input  wire                          o_stall,
    input  wire                          i_operation,
    input  wire                          i_last,
    input  wire                          o_valid,
    input  wire                          i_stall,
    input  wire  [lcs_pkg::SCORE_W-1:0]  o_length,
    input  wire                          o_overflow
);
    import lcs_pkg::*;

    // A result beat held by the sink keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_length) && $stable(o_overflow))
        else $error("result beat changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // A final second-string beat always keeps the core busy for its result.
    a_feed_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_operation == OP_FEED) && i_last |=> o_stall)
        else $error("final second-string beat did not occupy the core");

    // A first-string beat never stalls the beat after it.
    a_load_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_operation == OP_LOAD) |=> !o_stall)
        else $error("first-string beat stalled the next beat");

    // A reported length never exceeds the store depth.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (int'(o_length) <= MAX_LEN))
        else $error("reported length exceeds store depth");

endmodule

bind lcs_length_core lcs_checker u_lcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_operation (i_operation),
    .i_last      (i_last),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_length    (o_length),
    .o_overflow  (o_overflow)
);

`default_nettype wire
